@@ hw/rtl/csr_spmv_pkg.sv @@
// Shared types, opcodes and defaults for the CSR sparse matrix-vector MAC.
package csr_spmv_pkg;

  localparam int unsigned VectorDepthDefault = 4096;

  localparam int unsigned ColW   = 12;
  localparam int unsigned ValW   = 32;
  localparam int unsigned SumW   = 64;

  // Item opcodes; code 3 is unused and dropped.
  localparam logic [1:0] OpWrite = 2'd0;
  localparam logic [1:0] OpMac   = 2'd1;
  localparam logic [1:0] OpEmpty = 2'd2;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [ColW-1:0]        col_index;
    logic signed [ValW-1:0] data_value;
    logic                   row_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SumW-1:0] row_sum;
    logic                   row_overflow;
  } out_item_t;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

endpackage

@@ hw/rtl/csr_sparse_matrix_vector_mac.sv @@
// Top level: vector store, pipelined multiply and saturating row accumulator.
//
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   in_data_i  (in_item_t)
// out      output     out_valid_o / out_ready_i out_data_o (out_item_t)
//
// One item per cycle while the output is not stalled. An accepted item passes
// through the synchronous store read, the registered 32x32 product and the
// accumulation into the output register, in that order.
// Reset clears the pipeline valids, accumulator and overflow flag; the vector
// store is not cleared. When the output register holds an untaken result the
// whole pipe holds and in_ready_o drops.
module csr_sparse_matrix_vector_mac
  import csr_spmv_pkg::*;
#(
  parameter int unsigned VECTOR_DEPTH = VectorDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned AddrW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

  logic               advance;
  logic               in_acc;
  logic [AddrW-1:0]   addr;
  logic               in_range;

  logic [ValW-1:0]    vec_mem [VECTOR_DEPTH];
  logic [ValW-1:0]    rd_q;

  // stage 1: store read in flight
  logic                   s1_valid_q;
  logic [1:0]             s1_op_q;
  logic                   s1_end_q;
  logic                   s1_range_q;
  logic signed [ValW-1:0] s1_val_q;

  // stage 2: product
  logic                   s2_valid_q;
  logic [1:0]             s2_op_q;
  logic                   s2_end_q;
  logic signed [SumW-1:0] prod_q;
  logic signed [ValW-1:0] entry;

  // accumulate
  logic signed [SumW-1:0] acc_q, acc_d;
  logic                   ovf_q, ovf_d;
  logic signed [SumW:0]   sum_wide;
  logic signed [SumW-1:0] sum_sat;
  logic                   sat;
  logic                   emit;
  out_item_t              res;

  logic      out_valid_q;
  out_item_t out_q;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;
  assign in_acc     = in_valid_i && advance;
  assign addr       = AddrW'(in_data_i.col_index);
  assign in_range   = 32'(in_data_i.col_index) < 32'(VECTOR_DEPTH);

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.opcode == OpWrite && in_range) begin
      vec_mem[addr] <= in_data_i.data_value;
    end
    if (in_acc && in_data_i.opcode == OpMac) begin
      rd_q <= vec_mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_acc && (in_data_i.opcode == OpMac || in_data_i.opcode == OpEmpty);
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_op_q    <= in_data_i.opcode;
      s1_end_q   <= in_data_i.row_end;
      s1_range_q <= in_range;
      s1_val_q   <= in_data_i.data_value;
      s2_op_q    <= s1_op_q;
      s2_end_q   <= s1_end_q;
      prod_q     <= SumW'(s1_val_q) * SumW'(entry);
    end
  end

  // out-of-range columns read as zero
  assign entry = s1_range_q ? $signed(rd_q) : '0;

  always_comb begin
    sum_wide = {acc_q[SumW-1], acc_q} + {prod_q[SumW-1], prod_q};
    sat      = sum_wide[SumW] != sum_wide[SumW-1];
    sum_sat  = sat ? (sum_wide[SumW] ? SumMin : SumMax) : sum_wide[SumW-1:0];
    acc_d    = acc_q;
    ovf_d    = ovf_q;
    emit     = 1'b0;
    res      = '0;
    if (s2_valid_q) begin
      case (s2_op_q)
        OpMac: begin
          if (s2_end_q) begin
            emit             = 1'b1;
            res.row_sum      = sum_sat;
            res.row_overflow = ovf_q || sat;
            acc_d            = '0;
            ovf_d            = 1'b0;
          end else begin
            acc_d = sum_sat;
            ovf_d = ovf_q || sat;
          end
        end
        OpEmpty: begin
          emit  = 1'b1;
          acc_d = '0;
          ovf_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s2_valid_q && s2_op_q == OpEmpty
    |=> out_valid_o && out_data_o.row_sum == '0 && !out_data_o.row_overflow)
    else $error("empty row did not emit zero");

  a_row_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s2_valid_q && s2_op_q == OpMac && s2_end_q |=> out_valid_o)
    else $error("row end produced no result");

  a_sat_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s2_valid_q && s2_op_q == OpMac && !s2_end_q && sat |=> ovf_q)
    else $error("saturation did not set overflow flag");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(acc_q) && $stable(s2_valid_q))
    else $error("pipeline moved while stalled");

endmodule
